### rtl/core/tpci_pkg.sv
// Package for the text pin command interpreter: session phases, reply and
// action codes, character constants, token type and the number field parser.
// No dependencies.
package tpci_pkg;

    typedef enum logic [1:0] {
        PH_CLOSED = 2'd0,
        PH_LOGIN  = 2'd1,
        PH_CMD    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        NS_LEAD   = 2'd0,
        NS_DIGITS = 2'd1,
        NS_DONE   = 2'd2
    } t_num_st;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_OUTPUT = 3'd1;
    localparam logic [2:0] ACT_INPUT  = 3'd2;
    localparam logic [2:0] ACT_DWRITE = 3'd3;
    localparam logic [2:0] ACT_AWRITE = 3'd4;

    localparam logic [1:0] RPL_NONE   = 2'd0;
    localparam logic [1:0] RPL_OK     = 2'd1;
    localparam logic [1:0] RPL_FAIL   = 2'd2;
    localparam logic [1:0] RPL_DENIED = 2'd3;

    localparam logic [2:0] PREFIX_MISS = 3'd7;
    localparam logic [2:0] LOGIN_DONE  = 3'd3;
    localparam logic [2:0] EXIT_DONE   = 3'd4;

    localparam int unsigned TOKEN_KEEP = 7;
    localparam logic [4:0]  TOKEN_CAP  = 5'd31;

    localparam logic [2:0] PIN_FIRST = 3'd3;
    localparam logic [2:0] PIN_LAST  = 3'd7;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_BAR  = "|";

    localparam logic [2:0][7:0] LOGIN_KEY = {"3", "2", "1"};
    localparam logic [3:0][7:0] EXIT_WORD = {"t", "i", "x", "e"};

    typedef logic [TOKEN_KEEP-1:0][7:0] t_token;

    typedef struct packed {
        logic [2:0]        action;
        logic signed [7:0] pin;
        logic signed [10:0] value;
        logic [1:0]        reply;
    } t_result;

    function automatic logic is_blank(logic [7:0] c);
        return (c == " ") || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Decimal field of up to three characters: blanks, one sign, digits.
    function automatic logic signed [10:0] read_number(t_token tk, int unsigned start,
                                                       int unsigned n);
        logic [9:0] v;
        logic       neg;
        t_num_st    st;
        logic [7:0] c;
        v   = '0;
        neg = 1'b0;
        st  = NS_LEAD;
        c   = '0;
        for (int unsigned i = 0; i < 3; i++) begin
            if (i < n) begin
                c = tk[3'(start + i)];
                if (st == NS_LEAD && is_blank(c)) begin
                    st = NS_LEAD;
                end else if (st == NS_LEAD && (c == "+" || c == "-")) begin
                    neg = (c == "-");
                    st  = NS_DIGITS;
                end else if (st != NS_DONE && c >= "0" && c <= "9") begin
                    v  = 10'((v * 10) + 10'(c - "0"));
                    st = NS_DIGITS;
                end else begin
                    st = NS_DONE;
                end
            end
        end
        return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

### rtl/core/tpci_decode.sv
// Token decoder: turns one finished command token into a pin action result.
// Depends on tpci_pkg.
module tpci_decode (
    input  tpci_pkg::t_token  i_token,
    output tpci_pkg::t_result o_res
);

    logic [7:0]         c0, c1, c2, c3;
    logic signed [10:0] pin4;
    logic signed [10:0] pin5;
    logic signed [10:0] duty;

    assign c0   = i_token[0];
    assign c1   = i_token[1];
    assign c2   = i_token[2];
    assign c3   = i_token[3];
    assign pin4 = tpci_pkg::read_number(i_token, 4, 2);
    assign pin5 = tpci_pkg::read_number(i_token, 5, 2);
    assign duty = tpci_pkg::read_number(i_token, 2, 3);

    always_comb begin
        o_res.action = tpci_pkg::ACT_NONE;
        o_res.pin    = '0;
        o_res.value  = '0;
        o_res.reply  = tpci_pkg::RPL_FAIL;
        priority if (c0 == "P" && c1 == "M") begin
            if (c2 == "O" && c3 == "U") begin
                o_res.action = tpci_pkg::ACT_OUTPUT;
                o_res.pin    = pin4[7:0];
                o_res.reply  = tpci_pkg::RPL_OK;
            end else if (c2 == "I" && c3 == "N") begin
                o_res.action = tpci_pkg::ACT_INPUT;
                o_res.pin    = pin4[7:0];
                o_res.reply  = tpci_pkg::RPL_OK;
            end
        end else if (c0 == "D" && c1 == "W") begin
            if (c2 == "H" && c3 == "I") begin
                o_res.action = tpci_pkg::ACT_DWRITE;
                o_res.pin    = pin4[7:0];
                o_res.value  = 11'sd1;
                o_res.reply  = tpci_pkg::RPL_OK;
            end else if (c2 == "L" && c3 == "O") begin
                o_res.action = tpci_pkg::ACT_DWRITE;
                o_res.pin    = pin4[7:0];
                o_res.reply  = tpci_pkg::RPL_OK;
            end
        end else if (c0 == "A" && c1 == "W") begin
            o_res.action = tpci_pkg::ACT_AWRITE;
            o_res.pin    = pin5[7:0];
            o_res.value  = duty;
            o_res.reply  = tpci_pkg::RPL_OK;
        end else begin
            o_res.reply  = tpci_pkg::RPL_FAIL;
        end
    end

endmodule

### rtl/core/text_pin_command_interpreter_unit.sv
// Top level of the text pin command interpreter: line/token state, session
// control and the output word register. Depends on tpci_pkg, tpci_decode.
//
// Takes one word per clock, a connect event or a received byte, while the
// output register is free and no closing run is draining. Each word is
// handled in the cycle it is accepted and its first result lands in the
// output register the next cycle; the input is accepted again while that
// result is being taken. A closing run (access denied or exit) gives six
// result words; the input holds off while the five pin writes drain from the
// output register.
module text_pin_command_interpreter_unit #(
    parameter int LINE_BUFFER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] data_byte
    input  logic        i_s_tuser,  // [0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // [2:0] action, [10:3] pin_number,
                                    // [21:11] drive_value, [23:22] reply
    output logic        o_m_tuser,  // [0] session_closed
    output logic        o_m_tlast
);

    localparam int POS_W = $clog2(LINE_BUFFER_BYTES);

    tpci_pkg::t_phase  r_phase, n_phase;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [2:0]        r_prog, n_prog;
    logic              r_ign, n_ign;
    tpci_pkg::t_token  r_chars, n_chars;
    logic [4:0]        r_len, n_len;

    tpci_pkg::t_result r_res;
    logic              r_valid, r_closed, r_last;
    logic              r_run;
    logic [2:0]        r_run_pin;

    tpci_pkg::t_token  dec_chars;
    tpci_pkg::t_result dec_res;
    tpci_pkg::t_result n_res;
    logic              n_has, n_dec, n_close;
    logic              out_free, accept;
    logic [POS_W:0]    pos_nx;
    logic              line_end;
    logic [7:0]        b;

    tpci_decode u_decode (
        .i_token (dec_chars),
        .o_res   (dec_res)
    );

    assign out_free   = !r_valid || i_m_tready;
    assign o_s_tready = !r_run && out_free;
    assign accept     = i_s_tvalid && o_s_tready;
    assign b          = i_s_tdata;
    assign pos_nx     = {1'b0, r_pos} + (POS_W+1)'(1);
    assign line_end   = (b == tpci_pkg::CH_LF) || (pos_nx >= (POS_W+1)'(LINE_BUFFER_BYTES));

    // token as seen by the decoder, with this byte stored when it is a character
    always_comb begin
        dec_chars = r_chars;
        if (b != tpci_pkg::CH_NUL && b != tpci_pkg::CH_BAR
                && r_len < 5'(tpci_pkg::TOKEN_KEEP)) begin
            dec_chars[r_len[2:0]] = b;
        end
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_prog    = r_prog;
        n_ign     = r_ign;
        n_chars   = r_chars;
        n_len     = r_len;
        n_has     = 1'b0;
        n_dec     = 1'b0;
        n_close   = 1'b0;
        n_res     = '0;
        if (!i_s_tuser) begin
            n_phase   = tpci_pkg::PH_LOGIN;
            n_pos     = '0;
            n_prog    = '0;
            n_ign     = 1'b0;
            n_chars   = '0;
            n_len     = '0;
            n_has     = 1'b1;
            n_res.reply = tpci_pkg::RPL_OK;
        end else begin
            unique case (r_phase)
                tpci_pkg::PH_LOGIN: begin
                    n_pos = pos_nx[POS_W-1:0];
                    if (r_prog != tpci_pkg::PREFIX_MISS && r_pos < POS_W'(3)) begin
                        n_prog = (b == tpci_pkg::LOGIN_KEY[r_pos[1:0]]) ?
                                 r_prog + 3'd1 : tpci_pkg::PREFIX_MISS;
                    end
                    if (line_end) begin
                        n_has = 1'b1;
                        if (n_prog == tpci_pkg::LOGIN_DONE) begin
                            n_phase     = tpci_pkg::PH_CMD;
                            n_res.reply = tpci_pkg::RPL_OK;
                        end else begin
                            n_close     = 1'b1;
                            n_res.reply = tpci_pkg::RPL_DENIED;
                        end
                    end
                end
                tpci_pkg::PH_CMD: begin
                    n_pos = pos_nx[POS_W-1:0];
                    if (r_prog != tpci_pkg::PREFIX_MISS && r_pos < POS_W'(4)) begin
                        if (b == tpci_pkg::EXIT_WORD[r_pos[1:0]]) begin
                            n_prog = r_prog + 3'd1;
                            if (n_prog == tpci_pkg::EXIT_DONE) begin
                                n_ign = 1'b1;
                            end
                        end else begin
                            n_prog = tpci_pkg::PREFIX_MISS;
                        end
                    end
                    if (!n_ign) begin
                        if (b == tpci_pkg::CH_NUL || b == tpci_pkg::CH_BAR) begin
                            if (b == tpci_pkg::CH_NUL) begin
                                n_ign = 1'b1;
                            end
                            if (r_len != '0) begin
                                n_dec = 1'b1;
                            end
                            n_chars = '0;
                            n_len   = '0;
                        end else begin
                            if (r_len < 5'(tpci_pkg::TOKEN_KEEP)) begin
                                n_chars[r_len[2:0]] = b;
                            end
                            if (r_len < tpci_pkg::TOKEN_CAP) begin
                                n_len = r_len + 5'd1;
                            end
                        end
                    end
                    if (line_end) begin
                        if (n_prog == tpci_pkg::EXIT_DONE) begin
                            n_close     = 1'b1;
                            n_has       = 1'b1;
                            n_res.reply = tpci_pkg::RPL_OK;
                        end else if (!n_ign && n_len != '0) begin
                            n_dec = 1'b1;
                        end
                    end
                    if (n_dec && !n_close) begin
                        n_has = 1'b1;
                        n_res = dec_res;
                    end
                end
                default: begin
                end
            endcase
            if (n_has || line_end) begin
                if (n_close || line_end || (n_phase != r_phase)) begin
                    if (line_end) begin
                        n_pos   = '0;
                        n_prog  = '0;
                        n_ign   = 1'b0;
                        n_chars = '0;
                        n_len   = '0;
                    end
                end
            end
            if (r_phase == tpci_pkg::PH_CLOSED) begin
                n_pos   = r_pos;
            end
            if (n_close) begin
                n_phase = tpci_pkg::PH_CLOSED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tpci_pkg::PH_CLOSED;
            r_pos   <= '0;
            r_prog  <= '0;
            r_ign   <= 1'b0;
            r_chars <= '0;
            r_len   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_prog  <= n_prog;
            r_ign   <= n_ign;
            r_chars <= n_chars;
            r_len   <= n_len;
        end
    end

    // output word register and closing run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_run     <= 1'b0;
            r_run_pin <= tpci_pkg::PIN_FIRST;
        end else if (accept) begin
            r_valid   <= n_has;
            r_run     <= n_close;
            r_run_pin <= tpci_pkg::PIN_FIRST;
        end else if (r_run && out_free) begin
            r_valid   <= 1'b1;
            r_run     <= (r_run_pin != tpci_pkg::PIN_LAST);
            r_run_pin <= r_run_pin + 3'd1;
        end else if (i_m_tready) begin
            r_valid   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res    <= n_res;
            r_closed <= 1'b0;
            r_last   <= !n_close;
        end else if (r_run && out_free) begin
            r_res.action <= tpci_pkg::ACT_DWRITE;
            r_res.pin    <= 8'(r_run_pin);
            r_res.value  <= '0;
            r_res.reply  <= tpci_pkg::RPL_NONE;
            r_closed     <= (r_run_pin == tpci_pkg::PIN_LAST);
            r_last       <= (r_run_pin == tpci_pkg::PIN_LAST);
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_res.reply, r_res.value, r_res.pin, r_res.action};
    assign o_m_tuser  = r_closed;
    assign o_m_tlast  = r_last;

endmodule

### rtl/core/tpci_checker.sv
// Port-level checks for text_pin_command_interpreter_unit, bound to it below.
// Depends on tpci_pkg.
module tpci_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("session close not on last word of run");

    a_close_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[2:0] == tpci_pkg::ACT_DWRITE
                                    && o_m_tdata[10:3] == 8'd7
                                    && o_m_tdata[23:22] == tpci_pkg::RPL_NONE)
        else $error("closing word is not the last pin write");

    a_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] == tpci_pkg::ACT_NONE
            |-> o_m_tdata[23:22] != tpci_pkg::RPL_NONE && !o_m_tuser)
        else $error("result without action carries no reply");

endmodule

bind text_pin_command_interpreter_unit tpci_checker u_tpci_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_pin_command_interpreter_unit: login, command
// tokens, exit and closing runs, predicted per word and checked result by result.
// Depends on tpci_pkg and the RTL of the unit; needs nothing else.
module testbench;

    localparam int LINE_BYTES  = 32;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_WORDS = 15;
    localparam int TIMEOUT_NS  = 2_000_000;

    class interp_scoreboard;
        typedef struct packed {
            logic [2:0]         action;
            logic signed [7:0]  pin;
            logic signed [10:0] value;
            logic [1:0]         reply;
            logic               closed;
            logic               last;
        } t_pin_result;

        t_pin_result results_due[$];
        int          errors;
        int          words_taken;

        tpci_pkg::t_phase phase;
        int               line_pos;
        logic [2:0]       prefix;
        logic             line_ignored;
        tpci_pkg::t_token tok_chars;
        logic [4:0]       tok_len;

        function new();
            errors      = 0;
            words_taken = 0;
            phase       = tpci_pkg::PH_CLOSED;
            clear_line();
        endfunction

        function void clear_token();
            tok_chars = '0;
            tok_len   = '0;
        endfunction

        function void clear_line();
            line_pos     = 0;
            prefix       = '0;
            line_ignored = 1'b0;
            clear_token();
        endfunction

        function void add_result(logic [2:0] act, logic signed [10:0] pin_v,
                                 logic signed [10:0] val, logic [1:0] rpl,
                                 logic closed, logic last);
            t_pin_result r;
            r.action = act;
            r.pin    = pin_v[7:0];
            r.value  = val;
            r.reply  = rpl;
            r.closed = closed;
            r.last   = last;
            results_due.push_back(r);
        endfunction

        function logic [7:0] char_at(int i);
            return (i < tpci_pkg::TOKEN_KEEP) ? tok_chars[3'(i)] : 8'h00;
        endfunction

        function logic is_space(logic [7:0] c);
            return (c == " ") || (c >= 8'd9 && c <= 8'd13);
        endfunction

        // atoi over a fixed slot of the token
        function logic signed [10:0] parse_field(int first, int count);
            int   i;
            int   stop;
            int   acc;
            logic neg;
            i    = first;
            stop = first + count;
            acc  = 0;
            neg  = 1'b0;
            while (i < stop && is_space(char_at(i)))
                i++;
            if (i < stop && (char_at(i) == "+" || char_at(i) == "-")) begin
                neg = (char_at(i) == "-");
                i++;
            end
            while (i < stop && char_at(i) >= "0" && char_at(i) <= "9") begin
                acc = acc * 10 + int'(char_at(i) - "0");
                i++;
            end
            return 11'(neg ? -acc : acc);
        endfunction

        function void decode_token();
            logic [7:0] c0;
            logic [7:0] c1;
            logic [7:0] c2;
            logic [7:0] c3;
            c0 = char_at(0);
            c1 = char_at(1);
            c2 = char_at(2);
            c3 = char_at(3);
            if (c0 == "P" && c1 == "M") begin
                if (c2 == "O" && c3 == "U")
                    add_result(tpci_pkg::ACT_OUTPUT, parse_field(4, 2), '0,
                               tpci_pkg::RPL_OK, 1'b0, 1'b1);
                else if (c2 == "I" && c3 == "N")
                    add_result(tpci_pkg::ACT_INPUT, parse_field(4, 2), '0,
                               tpci_pkg::RPL_OK, 1'b0, 1'b1);
                else
                    add_result(tpci_pkg::ACT_NONE, '0, '0, tpci_pkg::RPL_FAIL, 1'b0, 1'b1);
            end else if (c0 == "D" && c1 == "W") begin
                if (c2 == "H" && c3 == "I")
                    add_result(tpci_pkg::ACT_DWRITE, parse_field(4, 2), 11'sd1,
                               tpci_pkg::RPL_OK, 1'b0, 1'b1);
                else if (c2 == "L" && c3 == "O")
                    add_result(tpci_pkg::ACT_DWRITE, parse_field(4, 2), '0,
                               tpci_pkg::RPL_OK, 1'b0, 1'b1);
                else
                    add_result(tpci_pkg::ACT_NONE, '0, '0, tpci_pkg::RPL_FAIL, 1'b0, 1'b1);
            end else if (c0 == "A" && c1 == "W") begin
                add_result(tpci_pkg::ACT_AWRITE, parse_field(5, 2), parse_field(2, 3),
                           tpci_pkg::RPL_OK, 1'b0, 1'b1);
            end else begin
                add_result(tpci_pkg::ACT_NONE, '0, '0, tpci_pkg::RPL_FAIL, 1'b0, 1'b1);
            end
        endfunction

        // reply, then pins 3..7 driven low
        function void closing_run(logic [1:0] rpl);
            add_result(tpci_pkg::ACT_NONE, '0, '0, rpl, 1'b0, 1'b0);
            for (int p = tpci_pkg::PIN_FIRST; p <= tpci_pkg::PIN_LAST; p++)
                add_result(tpci_pkg::ACT_DWRITE, 11'(p), '0, tpci_pkg::RPL_NONE,
                           p == tpci_pkg::PIN_LAST, p == tpci_pkg::PIN_LAST);
            phase = tpci_pkg::PH_CLOSED;
            clear_line();
        endfunction

        function void note_word(logic mode, logic [7:0] b);
            int   pos;
            logic line_end;
            if (!mode) begin
                words_taken++;
                phase = tpci_pkg::PH_LOGIN;
                clear_line();
                add_result(tpci_pkg::ACT_NONE, '0, '0, tpci_pkg::RPL_OK, 1'b0, 1'b1);
                return;
            end
            if (phase == tpci_pkg::PH_CLOSED)
                return;
            words_taken++;
            pos = line_pos;
            line_pos++;
            line_end = (b == tpci_pkg::CH_LF) || (line_pos >= LINE_BYTES);

            if (phase == tpci_pkg::PH_LOGIN) begin
                if (prefix != tpci_pkg::PREFIX_MISS && pos < 3)
                    prefix = (b == tpci_pkg::LOGIN_KEY[pos]) ?
                             prefix + 3'd1 : tpci_pkg::PREFIX_MISS;
                if (line_end) begin
                    if (prefix == tpci_pkg::LOGIN_DONE) begin
                        phase = tpci_pkg::PH_CMD;
                        clear_line();
                        add_result(tpci_pkg::ACT_NONE, '0, '0, tpci_pkg::RPL_OK, 1'b0, 1'b1);
                    end else begin
                        closing_run(tpci_pkg::RPL_DENIED);
                    end
                end
                return;
            end

            if (prefix != tpci_pkg::PREFIX_MISS && pos < 4) begin
                if (b == tpci_pkg::EXIT_WORD[pos]) begin
                    prefix = prefix + 3'd1;
                    if (prefix == tpci_pkg::EXIT_DONE)
                        line_ignored = 1'b1;
                end else begin
                    prefix = tpci_pkg::PREFIX_MISS;
                end
            end

            if (!line_ignored) begin
                if (b == tpci_pkg::CH_NUL || b == tpci_pkg::CH_BAR) begin
                    if (b == tpci_pkg::CH_NUL)
                        line_ignored = 1'b1;
                    if (tok_len != 0)
                        decode_token();
                    clear_token();
                end else begin
                    if (tok_len < tpci_pkg::TOKEN_KEEP)
                        tok_chars[tok_len[2:0]] = b;
                    if (tok_len < tpci_pkg::TOKEN_CAP)
                        tok_len = tok_len + 5'd1;
                end
            end

            if (line_end) begin
                if (prefix == tpci_pkg::EXIT_DONE) begin
                    closing_run(tpci_pkg::RPL_OK);
                    return;
                end
                if (!line_ignored && tok_len != 0)
                    decode_token();
                clear_line();
            end
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [23:0] data, logic closed_bit, logic last_bit);
            t_pin_result want;
            if (results_due.size() == 0) begin
                $display("%0t: unexpected word, expected nothing, actual %h %b %b",
                         $time, data, closed_bit, last_bit);
                errors++;
                return;
            end
            want = results_due.pop_front();
            compare_field("action", want.action, data[2:0]);
            compare_field("pin_number", want.pin, $signed(data[10:3]));
            compare_field("drive_value", want.value, $signed(data[21:11]));
            compare_field("reply", want.reply, data[23:22]);
            compare_field("session_closed", want.closed, closed_bit);
            compare_field("last_of_run", want.last, last_bit);
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'h00;
    logic        i_s_tuser  = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    logic        rx_hold   = 1'b0;
    int          idle_pct  = 0;
    int          stall_pct = 0;
    event        hold_kick;
    interp_scoreboard sb;

    text_pin_command_interpreter_unit #(
        .LINE_BUFFER_BYTES(LINE_BYTES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk)
        i_m_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);

    // long receiver hold-off, counted here
    initial begin
        forever begin
            @(hold_kick);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_word(o_m_tdata, o_m_tuser, o_m_tlast);
            if (i_s_tvalid && o_s_tready)
                sb.note_word(i_s_tuser, i_s_tdata);
        end
    end

    task automatic send_word(input logic mode, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_word(1'b1, s[k]);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] token_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == tpci_pkg::CH_BAR || c == tpci_pkg::CH_LF || c == tpci_pkg::CH_NUL);
        return c;
    endfunction

    function automatic logic [7:0] slot_char();
        case ($urandom_range(9))
            0:       return " ";
            1:       return "\t";
            2:       return "+";
            3:       return "-";
            4:       return 8'($urandom_range(255));
            default: return 8'("0" + $urandom_range(9));
        endcase
    endfunction

    task automatic send_slot(input int n);
        repeat (n) send_word(1'b1, slot_char());
    endtask

    task automatic send_token();
        case ($urandom_range(9))
            0: begin send_text("PMOU"); send_slot(2); end
            1: begin send_text("PMIN"); send_slot(2); end
            2: begin send_text("DWHI"); send_slot(2); end
            3: begin send_text("DWLO"); send_slot(2); end
            4, 5: begin
                send_text("AW");
                send_slot(3);
                send_slot(2);
            end
            6: begin
                send_text($urandom_range(1) ? "PM" : "DW");
                send_word(1'b1, 8'("A" + $urandom_range(25)));
                send_word(1'b1, 8'("A" + $urandom_range(25)));
                send_slot(2);
            end
            7: repeat ($urandom_range(8, 36)) send_word(1'b1, token_char());
            8: repeat ($urandom_range(1, 6)) send_word(1'b1, 8'($urandom_range(255)));
            default: begin
                // truncated token, slots run past its end
                case ($urandom_range(2))
                    0: send_text("AW");
                    1: send_text("PMOU");
                    default: send_text("DWH");
                endcase
                send_slot($urandom_range(0, 2));
            end
        endcase
    endtask

    task automatic command_line();
        int n_tok;
        if ($urandom_range(15) == 0) begin
            repeat (LINE_BYTES + $urandom_range(0, 6)) send_word(1'b1, token_char());
            send_word(1'b1, tpci_pkg::CH_LF);
            return;
        end
        n_tok = $urandom_range(1, 4);
        for (int t = 0; t < n_tok; t++) begin
            if (t != 0) begin
                send_word(1'b1, tpci_pkg::CH_BAR);
                if ($urandom_range(5) == 0)
                    send_word(1'b1, tpci_pkg::CH_BAR);
            end
            send_token();
        end
        if ($urandom_range(9) == 0) begin
            send_word(1'b1, tpci_pkg::CH_NUL);
            send_token();
        end
        if ($urandom_range(7) == 0)
            send_word(1'b1, tpci_pkg::CH_BAR);
        send_word(1'b1, tpci_pkg::CH_LF);
    endtask

    task automatic random_session();
        send_word(1'b0, 8'($urandom_range(255)));
        case ($urandom_range(9))
            0: begin
                repeat ($urandom_range(0, 3)) send_word(1'b1, 8'("0" + $urandom_range(3)));
                send_word(1'b1, tpci_pkg::CH_LF);
            end
            1: begin
                send_text("123");
                repeat (LINE_BYTES - 3) send_word(1'b1, token_char());
            end
            default: begin
                send_text("123");
                repeat ($urandom_range(0, 2)) send_word(1'b1, token_char());
                send_word(1'b1, tpci_pkg::CH_LF);
            end
        endcase
        repeat ($urandom_range(1, 3)) command_line();
        case ($urandom_range(9))
            0: send_text("exi\n");
            1: ;
            default: begin
                send_text("exit");
                repeat ($urandom_range(0, 3)) send_word(1'b1, token_char());
                send_word(1'b1, tpci_pkg::CH_LF);
            end
        endcase
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) send_word(1'b1, 8'($urandom_range(255)));
        if ($urandom_range(7) == 0)
            drain();
    endtask

    initial begin
        int goal;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(1'b1, 8'hFF);
        send_word(1'b0, 8'h00);
        send_text("123\n");
        send_text("PMIN+7||DWLO99|AW-99\t5|DWXY1|Q\n");
        send_text("PMOU");
        send_word(1'b1, tpci_pkg::CH_NUL);
        send_text("AW1\n");
        send_word(1'b0, 8'hFF);
        send_text("12\n");
        send_word(1'b0, 8'h5A);
        send_text("123\nexit|PMOU1\n");
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            goal = sb.words_taken + PHASE_WORDS;
            while (sb.words_taken < goal)
                random_session();
            drain();
        end

        // receiver held off while words keep coming
        idle_pct  = 0;
        stall_pct = 0;
        -> hold_kick;
        send_word(1'b0, 8'h3C);
        send_text("123\nPMOU01|PMIN02|DWHI03|DWLO04|AW12305\nexit\n");
        drain();

        repeat (16) @(posedge i_clk);
        if (sb.results_due.size() != 0) begin
            $display("%0t: results outstanding, expected 0, actual %0d",
                     $time, sb.results_due.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### text_pin_command_interpreter_unit.f
rtl/core/tpci_pkg.sv
rtl/core/tpci_decode.sv
rtl/core/text_pin_command_interpreter_unit.sv
rtl/core/tpci_checker.sv
verif/testbench.sv
